[hdl/cua_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Contiguous unit allocator package
// Shared widths, status codes and controller command types.
// ----------------------------------------------------------------------------
package cua_pkg;

    localparam int UNITS_DEFAULT   = 32;
    localparam int ID_BITS_DEFAULT = 8;

    localparam int PID_W    = 8;
    localparam int COUNT_W  = 6;
    localparam int START_W  = 5;
    localparam int FREED_W  = 6;
    localparam int STATUS_W = 2;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOFIT   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;

    localparam logic       OP_ALLOC = 1'b0;
    localparam logic       OP_FREE  = 1'b1;

    localparam logic [1:0] FIT_FIRST = 2'd0;
    localparam logic [1:0] FIT_NEXT  = 2'd1;
    localparam logic [1:0] FIT_BEST  = 2'd2;
    localparam logic [1:0] FIT_WORST = 2'd3;

    typedef struct packed {
        logic load;
        logic scan_step;
        logic scan_fin;
        logic fill_step;
        logic free_step;
    } cua_cmd_t;

    typedef struct packed {
        logic is_free;
        logic invalid;
        logic scan_last;
        logic found;
        logic fill_last;
        logic free_last;
    } cua_stat_t;

endpackage

[hdl/cua_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Contiguous unit allocator datapath
// Owner table, run tracker for the fit scan, fill and release sweeps.
// ----------------------------------------------------------------------------
module cua_datapath #(
    parameter int UNITS   = 32,
    parameter int ID_BITS = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  cua_pkg::cua_cmd_t             cmd,
    output cua_pkg::cua_stat_t            stat,
    input  logic                          operation,
    input  logic [1:0]                    fit_policy,
    input  logic [cua_pkg::PID_W-1:0]     owner_tag,
    input  logic [cua_pkg::COUNT_W-1:0]   unit_count,
    output logic [cua_pkg::STATUS_W-1:0]  res_status,
    output logic [cua_pkg::START_W-1:0]   res_start,
    output logic [cua_pkg::FREED_W-1:0]   res_freed
);
    import cua_pkg::*;

    localparam int IW = (UNITS > 1) ? $clog2(UNITS) : 1;
    localparam int LW = $clog2(UNITS + 1);

    logic [ID_BITS-1:0] owner_reg [UNITS];
    logic [UNITS-1:0]   used_reg;
    logic [IW-1:0]      nfs_reg;

    logic               op_reg;
    logic [1:0]         pol_reg;
    logic [ID_BITS-1:0] pid_reg;
    logic [LW-1:0]      cnt_reg;
    logic [IW-1:0]      idx_reg;
    logic [LW-1:0]      step_reg;
    logic [LW-1:0]      run_reg;
    logic [IW-1:0]      runpos_reg;
    logic               found_reg;
    logic [LW-1:0]      blen_reg;
    logic [IW-1:0]      bpos_reg;
    logic [LW-1:0]      freed_reg;
    logic [STATUS_W-1:0] status_reg;

    logic               cnt_bad;
    logic [LW-1:0]      run_now;
    logic [IW-1:0]      pos_now;
    logic               end_run;
    logic               take;
    logic [IW-1:0]      idx_inc;
    logic [IW-1:0]      start_now;
    logic               hit;

    assign cnt_bad = (unit_count == '0) || (32'(unit_count) > UNITS);
    assign idx_inc = (32'(idx_reg) == UNITS - 1) ? '0 : idx_reg + 1'b1;

    // Free-run length ending at idx for best and worst fit.
    always_comb
    begin
        if (used_reg[idx_reg])
        begin
            run_now = '0;
        end
        else
        begin
            run_now = run_reg + 1'b1;
        end
        pos_now = (run_reg == '0) ? idx_reg : runpos_reg;
        end_run = !used_reg[idx_reg] && ((32'(idx_reg) == UNITS - 1) || used_reg[idx_inc]);
    end

    // First/next: the run from a start is computed by a reverse sweep, kept in
    // fit_ok_reg, one bit per start unit that has enough free room.
    logic [UNITS-1:0] fit_ok_reg;

    always_comb
    begin
        take = 1'b0;
        if (end_run && (run_now >= cnt_reg))
        begin
            if (!found_reg)
            begin
                take = 1'b1;
            end
            else if (pol_reg == FIT_BEST)
            begin
                take = run_now < blen_reg;
            end
            else
            begin
                take = run_now > blen_reg;
            end
        end
    end

    assign start_now = bpos_reg;
    assign hit = used_reg[idx_reg] && (owner_reg[idx_reg] == pid_reg);

    // The scan for first and next fit visits units from the top down and
    // records, for each unit, whether the free run starting there fits. The
    // pick then walks the circular order in a second pass.
    logic [LW-1:0] rrun;
    logic          rev_phase_reg;
    assign rrun = used_reg[idx_reg] ? '0 : run_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
            nfs_reg  <= '0;
        end
        else
        begin
            if (cmd.fill_step)
            begin
                used_reg[idx_reg] <= 1'b1;
                if (stat.fill_last)
                begin
                    nfs_reg <= idx_inc;
                end
            end
            if (cmd.free_step && hit)
            begin
                used_reg[idx_reg] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fill_step)
        begin
            owner_reg[idx_reg] <= pid_reg;
        end
        if (cmd.free_step && hit)
        begin
            owner_reg[idx_reg] <= '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg        <= operation;
            pol_reg       <= fit_policy;
            pid_reg       <= owner_tag[ID_BITS-1:0];
            cnt_reg       <= LW'(unit_count);
            found_reg     <= 1'b0;
            blen_reg      <= '0;
            bpos_reg      <= '0;
            run_reg       <= '0;
            runpos_reg    <= '0;
            step_reg      <= '0;
            freed_reg     <= '0;
            rev_phase_reg <= (fit_policy == FIT_FIRST) || (fit_policy == FIT_NEXT);
            if ((fit_policy == FIT_FIRST) || (fit_policy == FIT_NEXT))
            begin
                idx_reg <= IW'(UNITS - 1);
            end
            else
            begin
                idx_reg <= '0;
            end
            status_reg <= (operation == OP_ALLOC && cnt_bad) ? ST_INVALID : ST_OK;
        end
        else if (cmd.scan_step)
        begin
            step_reg <= step_reg + 1'b1;
            if (rev_phase_reg)
            begin
                run_reg             <= rrun;
                fit_ok_reg[idx_reg] <= rrun >= cnt_reg;
                if (32'(step_reg) == UNITS - 1)
                begin
                    rev_phase_reg <= 1'b0;
                    step_reg      <= '0;
                    idx_reg       <= (pol_reg == FIT_NEXT) ? nfs_reg : '0;
                end
                else
                begin
                    idx_reg <= idx_reg - 1'b1;
                end
            end
            else if (pol_reg == FIT_FIRST || pol_reg == FIT_NEXT)
            begin
                if (!found_reg && fit_ok_reg[idx_reg])
                begin
                    found_reg <= 1'b1;
                    bpos_reg  <= idx_reg;
                end
                idx_reg <= idx_inc;
            end
            else
            begin
                run_reg    <= run_now;
                runpos_reg <= pos_now;
                if (take)
                begin
                    found_reg <= 1'b1;
                    blen_reg  <= run_now;
                    bpos_reg  <= pos_now;
                end
                if (end_run)
                begin
                    run_reg <= '0;
                end
                idx_reg <= idx_inc;
            end
        end
        else if (cmd.scan_fin)
        begin
            idx_reg  <= start_now;
            step_reg <= '0;
            if (!found_reg)
            begin
                status_reg <= ST_NOFIT;
            end
        end
        else if (cmd.fill_step)
        begin
            step_reg <= step_reg + 1'b1;
            idx_reg  <= idx_inc;
        end
        else if (cmd.free_step)
        begin
            step_reg <= step_reg + 1'b1;
            idx_reg  <= idx_inc;
            if (hit)
            begin
                freed_reg <= freed_reg + 1'b1;
            end
        end
    end

    assign stat.is_free   = op_reg == OP_FREE;
    assign stat.invalid   = status_reg == ST_INVALID;
    assign stat.scan_last = !rev_phase_reg && (32'(step_reg) == UNITS - 1);
    assign stat.found     = found_reg;
    assign stat.fill_last = (step_reg + 1'b1) == cnt_reg;
    assign stat.free_last = 32'(step_reg) == UNITS - 1;

    assign res_status = status_reg;
    assign res_start  = (status_reg == ST_OK && op_reg == OP_ALLOC) ?
                        START_W'(bpos_reg) : '0;
    assign res_freed  = (op_reg == OP_FREE) ? FREED_W'(freed_reg) : '0;

endmodule

[hdl/cua_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Contiguous unit allocator controller
// Sequences the scan, fill and release sweeps and issues the result strobe.
// ----------------------------------------------------------------------------
module cua_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    output logic                done,
    output cua_pkg::cua_cmd_t   cmd,
    input  cua_pkg::cua_stat_t  stat
);
    import cua_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_DEC, S_SCAN, S_FIN, S_FILL, S_FREE, S_DONE} state_t;

    state_t state_reg;
    logic   busy_reg;
    logic   done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= S_DEC;
                        busy_reg  <= 1'b1;
                    end
                end
                S_DEC:
                begin
                    if (stat.is_free)
                    begin
                        state_reg <= S_FREE;
                    end
                    else if (stat.invalid)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (stat.scan_last)
                    begin
                        state_reg <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    state_reg <= stat.found ? S_FILL : S_DONE;
                end
                S_FILL:
                begin
                    if (stat.fill_last)
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_FREE:
                begin
                    if (stat.free_last)
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    state_reg <= S_IDLE;
                    busy_reg  <= 1'b0;
                    done_reg  <= 1'b1;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_comb
    begin
        cmd           = '0;
        cmd.load      = (state_reg == S_IDLE) && start;
        cmd.scan_step = state_reg == S_SCAN;
        cmd.scan_fin  = state_reg == S_FIN;
        cmd.fill_step = state_reg == S_FILL;
        cmd.free_step = state_reg == S_FREE;
    end

    assign busy = busy_reg;
    assign done = done_reg;

endmodule

[hdl/contiguous_unit_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Contiguous unit allocator
// Owner table of UNITS units with first, next, best and worst fit allocation.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy stays high
// until its result. The result appears for one cycle with done high and
// cannot be stalled. First and next fit allocation make two sweeps over the
// owner table, one unit per cycle, then the fill; best and worst fit make one
// sweep, and a request that finds no run skips the fill. An invalid count goes
// straight to the result and a free request sweeps every unit once.
module contiguous_unit_allocator #(
    parameter int UNITS   = cua_pkg::UNITS_DEFAULT,
    parameter int ID_BITS = cua_pkg::ID_BITS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          operation,
    input  logic [1:0]                    fit_policy,
    input  logic [cua_pkg::PID_W-1:0]     owner_tag,
    input  logic [cua_pkg::COUNT_W-1:0]   unit_count,
    output logic                          done,
    output logic [cua_pkg::STATUS_W-1:0]  status,
    output logic [cua_pkg::START_W-1:0]   start_unit,
    output logic [cua_pkg::FREED_W-1:0]   units_freed
);
    import cua_pkg::*;

    cua_cmd_t  cmd;
    cua_stat_t stat;

    cua_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd),
        .stat  (stat)
    );

    cua_datapath #(
        .UNITS   (UNITS),
        .ID_BITS (ID_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .operation  (operation),
        .fit_policy (fit_policy),
        .owner_tag  (owner_tag),
        .unit_count (unit_count),
        .res_status (status),
        .res_start  (start_unit),
        .res_freed  (units_freed)
    );

endmodule
